// ----- rtl/pvpp_pkg.sv -----
// Shared types, constants and helpers of the phase vocoder bin phase propagator.
// No dependencies; imported by every module of the block.
package pvpp_pkg;

  // Field widths of the stream items
  localparam int BIN_W   = 10;
  localparam int PHASE_W = 16;
  localparam int TDATA_W = ((BIN_W + PHASE_W + 7) / 8) * 8;

  // Phase arithmetic: 2**PHASE_BITS units per turn, FFT length a power of two
  localparam int PHASE_BITS = 16;
  localparam int FFT_LEN    = 1024;
  localparam int FRAME_LOG2 = $clog2(FFT_LEN);
  localparam int ADV_SH     = PHASE_BITS - FRAME_LOG2;

  // Per-bin state stores
  localparam int BIN_DEPTH = 2 ** BIN_W;

  // Configuration registers
  localparam int AHOP_W     = 11;
  localparam int SHOP_W     = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [AHOP_W-1:0] AHOP_RST = AHOP_W'(256);
  localparam logic [SHOP_W-1:0] SHOP_RST = SHOP_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROBOT_MODE    = 2'd0,
    CFG_ANALYSIS_HOP  = 2'd1,
    CFG_SYNTHESIS_HOP = 2'd2
  } cfg_idx_e;

  // Scaled deviation: |deviation| * synthesis hop, divided by analysis hop
  localparam int PROD_W = PHASE_BITS + SHOP_W;
  localparam int ADV_PW = SHOP_W + BIN_W;

  // Item context that travels alongside the divider
  typedef struct packed {
    logic [BIN_W-1:0]      bin;
    logic                  neg;
    logic [PHASE_BITS-1:0] nom_s;
    logic                  robot;
  } pvpp_side_t;

  // Post-reset clearing sweep over both stores
  typedef struct packed {
    logic             busy;
    logic [BIN_W-1:0] addr;
  } pvpp_clr_t;

  // floor(hop * bin * turn / FFT_LEN) modulo one turn
  function automatic logic [PHASE_BITS-1:0] nom_adv(input logic [SHOP_W-1:0] hop,
                                                    input logic [BIN_W-1:0]  bin);
    logic [ADV_PW-1:0] prod;
    prod = ADV_PW'(hop) * ADV_PW'(bin);
    return {prod[FRAME_LOG2-1:0], {ADV_SH{1'b0}}};
  endfunction

endpackage

// ----- rtl/phase_vocoder_bin_phase_propagator.sv -----
// Top level of the phase vocoder bin phase propagator.
// Depends on pvpp_pkg, pvpp_front, pvpp_div and pvpp_back.
//
// Usage:
//   s_axis carries one spectral bin per transaction: bin index and analysis
//   phase (unsigned fraction of a turn). m_axis returns one transaction per
//   input: the bin echoed and the propagated synthesis phase.
//   The cfg port writes robot mode, analysis hop and synthesis hop; write it
//   only while no transaction is in flight.
//   Throughput is one bin per clock while the output is not stalled and the
//   sweep has finished. An item passes three front stages, one stage per quotient
//   bit of the 29-bit divider, the synthesis store read and the output register.
//   After reset a sweep zeroes both 1024-entry phase stores, one entry per
//   cycle: s_axis_tready stays low until the sweep ends; config writes are taken.
//   When the receiver stalls, the whole pipeline holds and s_axis_tready
//   drops in the same cycle; a finished result waits in the output register.
//   Repeated bins in flight are handled by forwarding in the back end.
module phase_vocoder_bin_phase_propagator
  import pvpp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,   // [9:0] bin_index, [25:10] analysis_phase
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,   // [9:0] out_bin, [25:10] synth_phase
  // Configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic              robot_q;
  logic [AHOP_W-1:0] ahop_q;
  logic [SHOP_W-1:0] shop_q;

  logic [BIN_W:0]    clr_cnt_q;
  pvpp_clr_t         clr;

  logic              en;
  logic              acc;

  logic              f_v;
  logic [PROD_W-1:0] f_prod;
  pvpp_side_t        f_side;
  logic              d_v;
  logic [PROD_W-1:0] d_quot;
  pvpp_side_t        d_side;

  logic              out_v;
  logic [BIN_W-1:0]  out_bin;
  logic [PHASE_W-1:0] out_phase;

  // Configuration registers; a zero analysis hop is held as one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      robot_q <= 1'b0;
      ahop_q  <= AHOP_RST;
      shop_q  <= SHOP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROBOT_MODE: begin
          robot_q <= cfg_wdata_i[0];
        end
        CFG_ANALYSIS_HOP: begin
          ahop_q <= (cfg_wdata_i[AHOP_W-1:0] == '0) ? AHOP_W'(1) : cfg_wdata_i[AHOP_W-1:0];
        end
        CFG_SYNTHESIS_HOP: begin
          shop_q <= cfg_wdata_i[SHOP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clr.busy) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign clr.busy = ~clr_cnt_q[BIN_W];
  assign clr.addr = clr_cnt_q[BIN_W-1:0];

  // Single pipeline enable: advance unless the output register is held
  assign en            = !out_v || m_axis_tready;
  assign s_axis_tready = en && !clr.busy;
  assign acc           = s_axis_tvalid && s_axis_tready;

  pvpp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .acc_i   (acc),
    .bin_i   (s_axis_tdata[BIN_W-1:0]),
    .phase_i (s_axis_tdata[BIN_W+PHASE_W-1:BIN_W]),
    .robot_i (robot_q),
    .ahop_i  (ahop_q),
    .shop_i  (shop_q),
    .clr_i   (clr),
    .v_o     (f_v),
    .prod_o  (f_prod),
    .side_o  (f_side)
  );

  pvpp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .v_i        (f_v),
    .dividend_i (f_prod),
    .divisor_i  (ahop_q),
    .side_i     (f_side),
    .v_o        (d_v),
    .quot_o     (d_quot),
    .side_o     (d_side)
  );

  pvpp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .v_i         (d_v),
    .quot_i      (d_quot),
    .side_i      (d_side),
    .clr_i       (clr),
    .out_v_o     (out_v),
    .out_bin_o   (out_bin),
    .out_phase_o (out_phase)
  );

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {{(TDATA_W - BIN_W - PHASE_W){1'b0}}, out_phase, out_bin};

  // Sweep steps one entry per cycle and never restarts once finished
  a_clr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr.busy |=> (clr_cnt_q == $past(clr_cnt_q) + 1'b1))
    else $error("clearing sweep skipped or stalled");

  a_clr_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr.busy |=> !clr.busy)
    else $error("clearing sweep restarted");

endmodule

// ----- rtl/pvpp_front.sv -----
// Front end: analysis phase store, phase deviation, wrap and magnitude scaling.
// Depends on pvpp_pkg; feeds pvpp_div.
module pvpp_front
  import pvpp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  acc_i,
  input  logic [BIN_W-1:0]      bin_i,
  input  logic [PHASE_W-1:0]    phase_i,
  input  logic                  robot_i,
  input  logic [AHOP_W-1:0]     ahop_i,
  input  logic [SHOP_W-1:0]     shop_i,
  input  pvpp_clr_t             clr_i,
  output logic                  v_o,
  output logic [PROD_W-1:0]     prod_o,
  output pvpp_side_t            side_o
);

  logic [PHASE_BITS-1:0] ana_mem [BIN_DEPTH];
  logic [PHASE_BITS-1:0] ana_rd_q;

  logic                  v1_q, v2_q, v3_q;
  logic [BIN_W-1:0]      bin1_q, bin2_q;
  logic [PHASE_BITS-1:0] ph1_q;
  logic                  rob1_q, rob2_q;
  logic [PHASE_BITS-1:0] noma1_q, noms1_q, noms2_q;
  logic                  neg2_q;
  logic [PHASE_BITS-1:0] mag2_q;
  logic [PROD_W-1:0]     prod3_q;
  pvpp_side_t            side3_q;

  logic [PHASE_BITS-1:0] raw_d;
  logic [PHASE_BITS-1:0] mag_d;
  logic [PHASE_BITS-1:0] ph_in;

  assign ph_in = PHASE_BITS'(phase_i);

  // Analysis store: old value read and new value written in the same cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ana_rd_q <= ana_mem[bin_i];
    end
    if (clr_i.busy) begin
      ana_mem[clr_i.addr] <= '0;
    end else if (acc_i && !robot_i) begin
      ana_mem[bin_i] <= ph_in;
    end
  end

  // Deviation wrapped to a signed half turn, then its magnitude
  always_comb begin
    raw_d = ph1_q - ana_rd_q - noma1_q;
    mag_d = raw_d[PHASE_BITS-1] ? (~raw_d + 1'b1) : raw_d;
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= acc_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bin1_q  <= bin_i;
      ph1_q   <= ph_in;
      rob1_q  <= robot_i;
      noma1_q <= nom_adv(SHOP_W'(ahop_i), bin_i);
      noms1_q <= nom_adv(shop_i, bin_i);

      bin2_q  <= bin1_q;
      rob2_q  <= rob1_q;
      noms2_q <= noms1_q;
      neg2_q  <= raw_d[PHASE_BITS-1];
      mag2_q  <= mag_d;

      prod3_q       <= PROD_W'(mag2_q) * PROD_W'(shop_i);
      side3_q.bin   <= bin2_q;
      side3_q.neg   <= neg2_q;
      side3_q.nom_s <= noms2_q;
      side3_q.robot <= rob2_q;
    end
  end

  assign v_o    = v3_q;
  assign prod_o = prod3_q;
  assign side_o = side3_q;

endmodule

// ----- rtl/pvpp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with item context.
// Depends on pvpp_pkg; sits between pvpp_front and pvpp_back.
module pvpp_div
  import pvpp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              v_i,
  input  logic [PROD_W-1:0] dividend_i,
  input  logic [AHOP_W-1:0] divisor_i,
  input  pvpp_side_t        side_i,
  output logic              v_o,
  output logic [PROD_W-1:0] quot_o,
  output pvpp_side_t        side_o
);

  localparam int N = PROD_W;

  logic [N-1:0]      v_q;
  logic [AHOP_W-1:0] rem_q  [N-1];
  logic [N-1:0]      dq_q   [N];
  pvpp_side_t        side_q [N];

  logic [AHOP_W-1:0] src_rem [N];
  logic [N-1:0]      src_dq  [N];
  logic [AHOP_W:0]   trial   [N];
  logic [N-1:0]      qbit;
  logic [AHOP_W-1:0] rem_d   [N];
  logic [N-1:0]      dq_d    [N];

  // One compare-subtract per stage; dividend shifts out as quotient bits shift in
  always_comb begin
    src_rem[0] = '0;
    src_dq[0]  = dividend_i;
    for (int i = 1; i < N; i++) begin
      src_rem[i] = rem_q[i-1];
      src_dq[i]  = dq_q[i-1];
    end
    for (int i = 0; i < N; i++) begin
      trial[i] = {src_rem[i], src_dq[i][N-1]};
      if (trial[i] >= {1'b0, divisor_i}) begin
        qbit[i]  = 1'b1;
        rem_d[i] = AHOP_W'(trial[i] - {1'b0, divisor_i});
      end else begin
        qbit[i]  = 1'b0;
        rem_d[i] = trial[i][AHOP_W-1:0];
      end
      dq_d[i] = {src_dq[i][N-2:0], qbit[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-2:0], v_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < N - 1; i++) begin
        rem_q[i] <= rem_d[i];
      end
      for (int i = 0; i < N; i++) begin
        dq_q[i] <= dq_d[i];
      end
      side_q[0] <= side_i;
      for (int i = 1; i < N; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign v_o    = v_q[N-1];
  assign quot_o = dq_q[N-1];
  assign side_o = side_q[N-1];

endmodule

// ----- rtl/pvpp_back.sv -----
// Back end: synthesis phase store with forwarding, final sum and output register.
// Depends on pvpp_pkg; takes the divider output of pvpp_div.
module pvpp_back
  import pvpp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               v_i,
  input  logic [PROD_W-1:0]  quot_i,
  input  pvpp_side_t         side_i,
  input  pvpp_clr_t          clr_i,
  output logic               out_v_o,
  output logic [BIN_W-1:0]   out_bin_o,
  output logic [PHASE_W-1:0] out_phase_o
);

  logic [PHASE_BITS-1:0] syn_mem [BIN_DEPTH];
  logic [PHASE_BITS-1:0] syn_rd_q;

  logic                  ve_q;
  logic [BIN_W-1:0]      bine_q;
  logic                  robe_q;
  logic [PHASE_BITS-1:0] parte_q;
  logic                  fwd_q;
  logic [PHASE_BITS-1:0] fwd_data_q;

  logic                  out_v_q;
  logic [BIN_W-1:0]      out_bin_q;
  logic [PHASE_W-1:0]    out_phase_q;

  logic [PHASE_BITS-1:0] q_lo;
  logic [PHASE_BITS-1:0] part_d;
  logic [PHASE_BITS-1:0] last_syn;
  logic [PHASE_BITS-1:0] res;
  logic                  wr_en;

  // Signed scaled deviation plus nominal synthesis advance
  always_comb begin
    q_lo   = quot_i[PHASE_BITS-1:0];
    part_d = side_i.nom_s + (side_i.neg ? (~q_lo + 1'b1) : q_lo);
  end

  // Previous synthesis phase, forwarded when the item ahead just wrote the same bin
  always_comb begin
    last_syn = fwd_q ? fwd_data_q : syn_rd_q;
    res      = last_syn + parte_q;
    wr_en    = en_i && ve_q && !robe_q;
  end

  // Synthesis store: read for the entering item, write-back of the leaving one
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      syn_rd_q <= syn_mem[side_i.bin];
    end
    if (clr_i.busy) begin
      syn_mem[clr_i.addr] <= '0;
    end else if (wr_en) begin
      syn_mem[bine_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q    <= 1'b0;
      fwd_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      ve_q    <= v_i;
      fwd_q   <= ve_q && !robe_q && (bine_q == side_i.bin);
      out_v_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bine_q      <= side_i.bin;
      robe_q      <= side_i.robot;
      parte_q     <= part_d;
      fwd_data_q  <= res;
      out_bin_q   <= bine_q;
      out_phase_q <= robe_q ? '0 : PHASE_W'(res);
    end
  end

  assign out_v_o     = out_v_q;
  assign out_bin_o   = out_bin_q;
  assign out_phase_o = out_phase_q;

  // No result can exist while the stores are still being cleared
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !clr_i.busy)
    else $error("result valid during clearing pass");

endmodule
